### src/lcdnw_pkg.sv
// Shared types, constants and the divide-by-ten helper for the LCD nibble writer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lcdnw_pkg;

    // request selector codes
    localparam logic [1:0] CMD_COMMAND = 2'd0;
    localparam logic [1:0] CMD_DATA    = 2'd1;
    localparam logic [1:0] CMD_NUMBER  = 2'd2;

    // register-select values
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // position command bases and characters
    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;

    // digits of a number: index 0 is the units, the top one the ten-thousands
    localparam int NUM_DIGITS = 5;
    localparam int NUM_DIV    = NUM_DIGITS - 1;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // nibble sequencing
    localparam int          STEP_W        = 4;
    localparam logic [STEP_W-1:0] NIB_LAST_BYTE = 4'd1;
    localparam logic [STEP_W-1:0] NIB_LAST_NUM  = 4'd13;

    // byte slots of a number request
    localparam logic [2:0] SLOT_POS   = 3'd0;
    localparam logic [2:0] SLOT_TTHOU = 3'd1;
    localparam logic [2:0] SLOT_THOU  = 3'd2;
    localparam logic [2:0] SLOT_HUND  = 3'd3;
    localparam logic [2:0] SLOT_TENS  = 3'd4;
    localparam logic [2:0] SLOT_DOT   = 3'd5;
    localparam logic [2:0] SLOT_UNITS = 3'd6;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        KIND_CMD,
        KIND_DATA,
        KIND_NUM,
        KIND_NONE
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [7:0]                    byte_val;
        logic [NUM_DIGITS-1:0][3:0]    digits;
    } t_job;

    typedef struct packed {
        t_kind                         kind;
        logic [7:0]                    byte_val;
        logic [15:0]                   rest;
        logic [NUM_DIV-1:0][3:0]       digits;
    } t_fstage;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [15:0] q;
        logic [3:0]  r;
    } t_split;

    function automatic t_split split10(input logic [15:0] x);
        logic [32:0] prod;
        logic [15:0] q;
        logic [15:0] q10;
        t_split      s;
        prod = 33'(x) * 33'(DIV10_MUL);
        q    = 16'(prod >> DIV10_SHIFT);
        q10  = (q << 3) + (q << 1);
        s.q  = q;
        s.r  = 4'(x - q10);
        return s;
    endfunction

endpackage

### src/lcdnw_if.sv
// Valid/ready channel interfaces of the LCD nibble writer: requests in, nibbles out.
// Stand-alone; field widths follow the request and nibble formats.
`timescale 1ns / 1ps

interface lcdnw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  byte_value;
    logic [5:0]  column;
    logic        row;
    logic [15:0] number;

    modport source (output valid, cmd, byte_value, column, row, number, input ready);
    modport sink   (input valid, cmd, byte_value, column, row, number, output ready);
endinterface

interface lcdnw_nib_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, reg_select, nibble, last, input ready);
    modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

### src/lcdnw_front.sv
// Front end: accepts requests, classifies them, builds the position byte and
// splits the number into decimal digits in a divide-by-ten pipeline. Uses lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_front import lcdnw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lcdnw_req_if.sink       i_req,
    input  t_q_stat         i_q_stat,
    output logic            o_push,
    output t_job            o_job
);

    logic    [NUM_DIV:0] r_vld;
    t_fstage             r_stg [NUM_DIV+1];
    t_fstage             n_stg [NUM_DIV+1];
    t_split              div_res [NUM_DIV];
    logic                adv;
    logic                tail_drop;

    // requests with an unused selector flow through and are dropped here
    assign tail_drop = r_stg[NUM_DIV].kind == KIND_NONE;
    assign adv       = !r_vld[NUM_DIV] || tail_drop || !i_q_stat.full;
    assign o_push    = r_vld[NUM_DIV] && !tail_drop && !i_q_stat.full;

    assign i_req.ready = adv;

    assign o_job.kind     = r_stg[NUM_DIV].kind;
    assign o_job.byte_val = r_stg[NUM_DIV].byte_val;
    assign o_job.digits   = {r_stg[NUM_DIV].rest[3:0], r_stg[NUM_DIV].digits};

    always_comb begin
        n_stg[0].rest   = i_req.number;
        n_stg[0].digits = '0;
        unique case (i_req.cmd)
            CMD_COMMAND: begin
                n_stg[0].kind     = KIND_CMD;
                n_stg[0].byte_val = i_req.byte_value;
            end
            CMD_DATA: begin
                n_stg[0].kind     = KIND_DATA;
                n_stg[0].byte_val = i_req.byte_value;
            end
            CMD_NUMBER: begin
                n_stg[0].kind     = KIND_NUM;
                n_stg[0].byte_val = (i_req.row ? ROW1_BASE : ROW0_BASE)
                                    + {2'b00, i_req.column};
            end
            default: begin
                n_stg[0].kind     = KIND_NONE;
                n_stg[0].byte_val = i_req.byte_value;
            end
        endcase

        // each stage peels off one decimal digit, units first
        for (int k = 1; k <= NUM_DIV; k++) begin
            div_res[k-1]       = split10(r_stg[k-1].rest);
            n_stg[k]           = r_stg[k-1];
            n_stg[k].rest      = div_res[k-1].q;
            n_stg[k].digits[k-1] = div_res[k-1].r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NUM_DIV-1:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= NUM_DIV; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> (r_vld[NUM_DIV] && i_q_stat.full))
        else $error("front pipeline stalled without a blocked tail");

endmodule

### src/lcdnw_queue.sv
// Two-entry job queue between the front end and the nibble sequencer.
// Uses t_job and t_q_stat from lcdnw_pkg.
`timescale 1ns / 1ps

module lcdnw_queue import lcdnw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_job        i_push_job,
    input  logic        i_pop,
    output t_q_stat     o_stat,
    output t_job        o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue popped while empty");

endmodule

### src/lcdnw_back.sv
// Back end: walks each queued job nibble by nibble into the output register.
// Uses lcdnw_pkg and the lcdnw_nib_if channel.
`timescale 1ns / 1ps

module lcdnw_back import lcdnw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_job        i_head,
    output logic        o_pop,
    lcdnw_nib_if.source o_nib
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_job              r_job;
    logic              r_out_vld;
    logic              r_out_rs;
    logic [3:0]        r_out_nib;
    logic              r_out_last;

    t_job              cur;
    logic [STEP_W-1:0] step;
    logic [2:0]        slot;
    logic [7:0]        cur_byte;
    logic              cur_rs;
    logic              cur_last;
    logic              have;
    logic              out_free;
    logic              emit;

    assign cur      = r_busy ? r_job : i_head;
    assign step     = r_busy ? r_step : '0;
    assign slot     = step[STEP_W-1:1];
    assign have     = r_busy || !i_q_stat.empty;
    assign out_free = !r_out_vld || o_nib.ready;
    assign emit     = have && out_free;
    assign o_pop    = emit && !r_busy;
    assign cur_last = step == ((cur.kind == KIND_NUM) ? NIB_LAST_NUM : NIB_LAST_BYTE);

    always_comb begin
        cur_rs   = RS_DATA;
        cur_byte = cur.byte_val;
        if (cur.kind == KIND_NUM) begin
            unique case (slot)
                SLOT_POS: begin
                    cur_rs   = RS_COMMAND;
                    cur_byte = cur.byte_val;
                end
                SLOT_TTHOU: cur_byte = ASCII_ZERO | {4'h0, cur.digits[4]};
                SLOT_THOU:  cur_byte = ASCII_ZERO | {4'h0, cur.digits[3]};
                SLOT_HUND:  cur_byte = ASCII_ZERO | {4'h0, cur.digits[2]};
                SLOT_TENS:  cur_byte = ASCII_ZERO | {4'h0, cur.digits[1]};
                SLOT_DOT:   cur_byte = ASCII_DOT;
                SLOT_UNITS: cur_byte = ASCII_ZERO | {4'h0, cur.digits[0]};
                default:    cur_byte = ASCII_DOT;
            endcase
        end else if (cur.kind == KIND_CMD) begin
            cur_rs = RS_COMMAND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (emit) begin
                r_busy <= !cur_last;
                r_step <= step + 1'b1;
            end
            if (out_free) begin
                r_out_vld <= have;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (emit) begin
            r_out_rs   <= cur_rs;
            r_out_nib  <= step[0] ? cur_byte[3:0] : cur_byte[7:4];
            r_out_last <= cur_last;
        end
    end

    assign o_nib.valid      = r_out_vld;
    assign o_nib.reg_select = r_out_rs;
    assign o_nib.nibble     = r_out_nib;
    assign o_nib.last       = r_out_last;

    a_busy_past_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step != '0)
        else $error("sequencer busy at the first nibble");

    a_byte_job_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.kind != KIND_NUM) |-> r_step == NIB_LAST_BYTE)
        else $error("byte job ran past its low nibble");

endmodule

### src/char_lcd_nibble_number_writer_core.sv
// Character-LCD 4-bit bus writer: requests in, register-select tagged nibbles out.
//
// Channels: i_req carries one request (cmd, byte_value, column, row, number);
// o_nib carries one nibble (reg_select, nibble, last). Both move a request or a
// nibble at each rising edge where valid and ready are high.
// cmd 0 and cmd 1 give two nibbles, high first, to the command or data
// register. cmd 2 gives fourteen: the position command, then the digits as
// DDDD.D in ASCII. cmd 3 gives nothing. last marks the final nibble.
// Path: the first nibble of a request goes through the capture register on the
// accepting edge, then four divide-by-ten stages, the queue and the output
// register.
// Flow: one nibble per cycle from the single output register while o_nib.ready
// is high and a job is waiting; the input takes a request every cycle until the
// last digit stage holds a request that the full queue cannot take.
// Reset: clears the pipeline, queue and output register; no nibble is pending.
// Stall: while o_nib.ready is low the nibble holds, the sequencer waits, the
// queue fills, and then the whole digit pipeline holds with i_req.ready low.
`timescale 1ns / 1ps

module char_lcd_nibble_number_writer_core import lcdnw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdnw_req_if.sink   i_req,
    lcdnw_nib_if.source o_nib
);

    logic    push;
    t_job    push_job;
    logic    pop;
    t_q_stat q_stat;
    t_job    head;

    lcdnw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    lcdnw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_stat     (q_stat),
        .o_head     (head)
    );

    lcdnw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_nib    (o_nib)
    );

endmodule

### tb/char_lcd_nibble_number_writer_core_tb.sv
// Self-checking bench for the LCD nibble writer: random and directed requests in,
// every nibble checked in order against a local model of the bus writes.
// Depends on lcdnw_pkg, the channel interfaces and char_lcd_nibble_number_writer_core.
`timescale 1ns / 1ps

module char_lcd_nibble_number_writer_core_tb;
    import lcdnw_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 300;
    localparam int TAIL_REQUESTS   = 40;
    localparam int LONG_HOLD       = 400;
    localparam int HOLD_AFTER_NIBS = 120;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  byte_value;
        logic [5:0]  column;
        logic        row;
        logic [15:0] number;
    } t_lcd_request;

    typedef struct {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } t_bus_nibble;

    logic i_clk;
    logic i_rst_n;

    lcdnw_req_if req_ch ();
    lcdnw_nib_if nib_ch ();

    char_lcd_nibble_number_writer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_nib   (nib_ch)
    );

    t_lcd_request pending_requests[$];
    t_bus_nibble  bus_writes_due[$];

    bit stimulus_loaded = 1'b0;
    int error_count     = 0;
    int send_gap        = 0;
    int sink_hold       = 0;
    bit long_hold_done  = 1'b0;
    int nibbles_seen    = 0;
    int quiet_cycles    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- model
    function automatic void queue_byte_writes(input logic rs, input logic [7:0] value);
        t_bus_nibble n;
        n.reg_select = rs;
        n.last       = 1'b0;
        n.nibble     = value[7:4];
        bus_writes_due.push_back(n);
        n.nibble     = value[3:0];
        bus_writes_due.push_back(n);
    endfunction

    function automatic void predict_bus_writes(input t_lcd_request r);
        logic [7:0]  position;
        int unsigned value;
        value = r.number;
        case (r.cmd)
            CMD_COMMAND: queue_byte_writes(RS_COMMAND, r.byte_value);
            CMD_DATA:    queue_byte_writes(RS_DATA, r.byte_value);
            CMD_NUMBER: begin
                position = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, r.column};
                queue_byte_writes(RS_COMMAND, position);
                queue_byte_writes(RS_DATA, ASCII_ZERO + 8'(value / 10000));
                queue_byte_writes(RS_DATA, ASCII_ZERO + 8'((value / 1000) % 10));
                queue_byte_writes(RS_DATA, ASCII_ZERO + 8'((value / 100) % 10));
                queue_byte_writes(RS_DATA, ASCII_ZERO + 8'((value / 10) % 10));
                queue_byte_writes(RS_DATA, ASCII_DOT);
                queue_byte_writes(RS_DATA, ASCII_ZERO + 8'(value % 10));
            end
            default: return;
        endcase
        bus_writes_due[bus_writes_due.size() - 1].last = 1'b1;
    endfunction

    function automatic bit in_tail();
        return stimulus_loaded && (pending_requests.size() < TAIL_REQUESTS);
    endfunction

    // ------------------------------------------------------------ stimulus
    task automatic add_request(input logic [1:0] cmd, input logic [7:0] byte_value,
                               input logic [5:0] column, input logic row,
                               input logic [15:0] number);
        t_lcd_request r;
        r.cmd        = cmd;
        r.byte_value = byte_value;
        r.column     = column;
        r.row        = row;
        r.number     = number;
        pending_requests.push_back(r);
    endtask

    // ---------------------------------------------------------- request side
    always @(posedge i_clk) begin
        t_lcd_request seen;
        t_lcd_request next_req;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                seen.cmd        = req_ch.cmd;
                seen.byte_value = req_ch.byte_value;
                seen.column     = req_ch.column;
                seen.row        = req_ch.row;
                seen.number     = req_ch.number;
                predict_bus_writes(seen);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 18) - 1;
                    req_ch.valid <= 1'b0;
                end else begin
                    next_req = pending_requests.pop_front();
                    req_ch.cmd        <= next_req.cmd;
                    req_ch.byte_value <= next_req.byte_value;
                    req_ch.column     <= next_req.column;
                    req_ch.row        <= next_req.row;
                    req_ch.number     <= next_req.number;
                    req_ch.valid      <= 1'b1;
                end
            end
        end
    end

    // ----------------------------------------------------------- nibble side
    always @(posedge i_clk) begin
        t_bus_nibble want;
        if (!i_rst_n) begin
            nib_ch.ready <= 1'b0;
        end else begin
            if (nib_ch.valid && nib_ch.ready) begin
                nibbles_seen = nibbles_seen + 1;
                if (bus_writes_due.size() == 0) begin
                    $error("unexpected nibble: reg_select %0d nibble %0h last %0d",
                           nib_ch.reg_select, nib_ch.nibble, nib_ch.last);
                    error_count = error_count + 1;
                end else begin
                    want = bus_writes_due.pop_front();
                    if (nib_ch.reg_select !== want.reg_select) begin
                        $error("reg_select: expected %0d, got %0d",
                               want.reg_select, nib_ch.reg_select);
                        error_count = error_count + 1;
                    end
                    if (nib_ch.nibble !== want.nibble) begin
                        $error("nibble: expected %0h, got %0h", want.nibble, nib_ch.nibble);
                        error_count = error_count + 1;
                    end
                    if (nib_ch.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, nib_ch.last);
                        error_count = error_count + 1;
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold = sink_hold - 1;
                nib_ch.ready <= 1'b0;
            end else if (!long_hold_done && !in_tail() && nibbles_seen >= HOLD_AFTER_NIBS) begin
                // hold off long enough for the queue and pipeline to back up
                long_hold_done = 1'b1;
                sink_hold = LONG_HOLD - 1;
                nib_ch.ready <= 1'b0;
            end else if (!in_tail() && $urandom_range(0, 11) == 0) begin
                sink_hold = $urandom_range(1, 18) - 1;
                nib_ch.ready <= 1'b0;
            end else begin
                nib_ch.ready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (nib_ch.valid && nib_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------ main flow
    initial begin
        int issued;
        int pick;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_COMMAND;
        req_ch.byte_value = 8'h00;
        req_ch.column     = 6'd0;
        req_ch.row        = 1'b0;
        req_ch.number     = 16'd0;
        nib_ch.ready      = 1'b0;

        // byte extremes on both registers; unused fields carry noise
        add_request(CMD_COMMAND, 8'h00, 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_COMMAND, 8'hFF, 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_COMMAND, 8'h5A, 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_DATA, 8'h00, 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_DATA, 8'hFF, 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_DATA, 8'hA5, 6'($urandom), 1'($urandom), 16'($urandom));
        // number extremes, columns past the visible 40, largest leading digit
        add_request(CMD_NUMBER, 8'($urandom), 6'd0, 1'b0, 16'd0);
        add_request(CMD_NUMBER, 8'($urandom), 6'd63, 1'b1, 16'd65535);
        add_request(CMD_NUMBER, 8'($urandom), 6'd39, 1'b0, 16'd12345);
        add_request(CMD_NUMBER, 8'($urandom), 6'd40, 1'b1, 16'd60000);
        add_request(CMD_NUMBER, 8'($urandom), 6'd63, 1'b0, 16'd9);
        add_request(CMD_NUMBER, 8'($urandom), 6'd0, 1'b1, 16'd10000);
        add_request(CMD_NUMBER, 8'($urandom), 6'd21, 1'b0, 16'd9999);
        // unused selector between real requests
        add_request(CMD_UNUSED, 8'($urandom), 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_DATA, 8'h2E, 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_UNUSED, 8'($urandom), 6'($urandom), 1'($urandom), 16'($urandom));
        add_request(CMD_UNUSED, 8'($urandom), 6'($urandom), 1'($urandom), 16'($urandom));

        issued = 0;
        while (issued < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 2) begin
                add_request(CMD_COMMAND, 8'($urandom), 6'($urandom), 1'($urandom),
                            16'($urandom));
                issued = issued + 1;
            end else if (pick <= 5) begin
                add_request(CMD_DATA, 8'($urandom), 6'($urandom), 1'($urandom),
                            16'($urandom));
                issued = issued + 1;
            end else if (pick <= 8) begin
                add_request(CMD_NUMBER, 8'($urandom), 6'($urandom_range(0, 63)),
                            1'($urandom), 16'($urandom_range(0, 65535)));
                issued = issued + 1;
            end else begin
                add_request(CMD_UNUSED, 8'($urandom), 6'($urandom), 1'($urandom),
                            16'($urandom));
            end
        end
        stimulus_loaded = 1'b1;

        while (pending_requests.size() != 0 || req_ch.valid) @(posedge i_clk);
        while (bus_writes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bus_writes_due.size() != 0) begin
            $error("%0d nibbles never arrived", bus_writes_due.size());
            error_count = error_count + 1;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
